// File: design/gcpp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcpp_pkg
// Shared types, codes and tables of the command packet parser.
// ----------------------------------------------------------------------------
package gcpp_pkg;

  localparam int CONST_WORDS      = 1024;
  localparam int CONST_AW         = $clog2(CONST_WORDS);
  localparam int CONST_CW         = $clog2(CONST_WORDS + 1);
  localparam int MAX_BUFFER_WORDS = 65536;
  localparam int NAMED_COUNT      = 10;
  localparam int CTX_SLOTS        = 3;

  localparam logic [31:0] CTX_BASE = 32'h0000_A000;

  localparam logic [1:0] TYPE0 = 2'd0;
  localparam logic [1:0] TYPE3 = 2'd3;

  localparam logic [7:0] OP_NOP          = 8'h10;
  localparam logic [7:0] OP_DRAW_INDEXED = 8'h27;
  localparam logic [7:0] OP_DRAW_AUTO    = 8'h2D;
  localparam logic [7:0] OP_SURF_SYNC    = 8'h43;
  localparam logic [7:0] OP_EOP_EVENT    = 8'h47;
  localparam logic [7:0] OP_CTX_SET      = 8'h69;
  localparam logic [7:0] OP_CONST_SET    = 8'h6A;

  typedef enum logic [1:0] {
    MODE_HEADER,
    MODE_BODY0,
    MODE_BODY3,
    MODE_DROP
  } mode_t;

  typedef enum logic [2:0] {
    ACT_NONE      = 3'd0,
    ACT_NAMED     = 3'd1,
    ACT_CONST     = 3'd2,
    ACT_DRAW_AUTO = 3'd3,
    ACT_DRAW_IDX  = 3'd4,
    ACT_UNHANDLED = 3'd5,
    ACT_TRUNC     = 3'd6
  } action_t;

  typedef struct packed {
    mode_t        mode;
    logic [14:0]  words_left;
    logic [13:0]  position;
    logic [7:0]   opcode;
    logic [31:0]  base;
  } ctrl_t;

  typedef struct packed {
    action_t      action;
    logic [3:0]   reg_slot;
    logic [9:0]   const_index;
    logic [31:0]  value;
    logic         buffer_end;
  } result_t;

  typedef struct packed {
    logic                named_we;
    logic [3:0]          named_slot;
    logic                const_we;
    logic [CONST_AW-1:0] const_addr;
    logic [31:0]         data;
  } wr_t;

  function automatic logic [31:0] slot_addr(input logic [3:0] s);
    logic [31:0] a;
    unique case (s)
      4'd0:    a = 32'h0000_A010;
      4'd1:    a = 32'h0000_A011;
      4'd2:    a = 32'h0000_A01C;
      4'd3:    a = 32'h0000_A105;
      4'd4:    a = 32'h0000_A106;
      4'd5:    a = 32'h0000_A0D4;
      4'd6:    a = 32'h0000_A094;
      4'd7:    a = 32'h0000_A0A8;
      4'd8:    a = 32'h0000_A0B0;
      4'd9:    a = 32'h0000_A29B;
      default: a = 32'hFFFF_FFFF;
    endcase
    return a;
  endfunction

  function automatic logic opcode_known(input logic [7:0] op);
    return (op == OP_NOP) || (op == OP_DRAW_INDEXED) || (op == OP_DRAW_AUTO) ||
           (op == OP_SURF_SYNC) || (op == OP_EOP_EVENT) || (op == OP_CTX_SET) ||
           (op == OP_CONST_SET);
  endfunction

endpackage

// File: design/gcpp_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcpp_step
// Per-word parse step: next control state, result word and store writes.
// ----------------------------------------------------------------------------
module gcpp_step (
  input  gcpp_pkg::ctrl_t   ctrl,
  input  logic [31:0]       cmd_word,
  input  logic [15:0]       words_after,
  output gcpp_pkg::ctrl_t   ctrl_nxt,
  output gcpp_pkg::result_t res,
  output gcpp_pkg::wr_t     wr
);
  import gcpp_pkg::*;

  logic [14:0] cnt;
  logic [31:0] addr0;
  logic [31:0] addr3;
  logic [32:0] ci;
  logic [13:0] pos_m1;
  logic        hit0;
  logic [3:0]  slot0;
  logic        hit3;
  logic [3:0]  slot3;
  logic [14:0] left_dec;

  assign cnt      = {1'b0, cmd_word[29:16]} + 15'd1;
  assign pos_m1   = ctrl.position - 14'd1;
  assign addr0    = ctrl.base + {18'd0, ctrl.position};
  assign addr3    = CTX_BASE + ctrl.base + {18'd0, pos_m1};
  assign ci       = {1'b0, ctrl.base} + {19'd0, pos_m1};
  assign left_dec = (ctrl.words_left != 15'd0) ? ctrl.words_left - 15'd1 : 15'd0;

  always_comb begin
    hit0  = 1'b0;
    slot0 = 4'd0;
    hit3  = 1'b0;
    slot3 = 4'd0;
    for (int s = NAMED_COUNT - 1; s >= 0; s--) begin
      if (addr0 == slot_addr(4'(s))) begin
        hit0  = 1'b1;
        slot0 = 4'(s);
      end
    end
    for (int s = CTX_SLOTS - 1; s >= 0; s--) begin
      if (addr3 == slot_addr(4'(s))) begin
        hit3  = 1'b1;
        slot3 = 4'(s);
      end
    end
  end

  always_comb begin
    ctrl_nxt       = ctrl;
    res.action     = ACT_NONE;
    res.reg_slot   = 4'd0;
    res.const_index = 10'd0;
    res.value      = 32'd0;
    res.buffer_end = (words_after == 16'd0);
    wr.named_we    = 1'b0;
    wr.named_slot  = 4'd0;
    wr.const_we    = 1'b0;
    wr.const_addr  = ci[CONST_AW-1:0];
    wr.data        = cmd_word;

    unique case (ctrl.mode) inside
      MODE_HEADER: begin
        if (cmd_word[31:30] == TYPE0 || cmd_word[31:30] == TYPE3) begin
          if ({1'b0, cnt} > words_after) begin
            res.action    = ACT_TRUNC;
            ctrl_nxt.mode = MODE_DROP;
          end else begin
            ctrl_nxt.words_left = cnt;
            ctrl_nxt.position   = 14'd0;
            if (cmd_word[31:30] == TYPE0) begin
              ctrl_nxt.base = {16'd0, cmd_word[15:0]};
              ctrl_nxt.mode = MODE_BODY0;
            end else begin
              ctrl_nxt.opcode = cmd_word[15:8];
              ctrl_nxt.mode   = MODE_BODY3;
              if (!opcode_known(cmd_word[15:8])) begin
                res.action = ACT_UNHANDLED;
                res.value  = {24'd0, cmd_word[15:8]};
              end
            end
          end
        end
      end
      MODE_BODY0, MODE_BODY3: begin
        if (ctrl.mode == MODE_BODY0) begin
          if (hit0) begin
            res.action    = ACT_NAMED;
            res.reg_slot  = slot0;
            res.value     = cmd_word;
            wr.named_we   = 1'b1;
            wr.named_slot = slot0;
          end
        end else if (ctrl.opcode == OP_CTX_SET || ctrl.opcode == OP_CONST_SET) begin
          if (ctrl.position == 14'd0) begin
            ctrl_nxt.base = cmd_word;
          end else if (ctrl.opcode == OP_CTX_SET) begin
            if (hit3) begin
              res.action    = ACT_NAMED;
              res.reg_slot  = slot3;
              res.value     = cmd_word;
              wr.named_we   = 1'b1;
              wr.named_slot = slot3;
            end
          end else if (ci < 33'(CONST_WORDS)) begin
            res.action      = ACT_CONST;
            res.const_index = ci[9:0];
            res.value       = cmd_word;
            wr.const_we     = 1'b1;
          end
        end else if (ctrl.opcode == OP_DRAW_AUTO && ctrl.position == 14'd0) begin
          res.action = ACT_DRAW_AUTO;
          res.value  = cmd_word;
        end else if (ctrl.opcode == OP_DRAW_INDEXED && ctrl.position == 14'd2) begin
          res.action = ACT_DRAW_IDX;
          res.value  = cmd_word;
        end
        ctrl_nxt.position   = ctrl.position + 14'd1;
        ctrl_nxt.words_left = left_dec;
        if (left_dec == 15'd0) begin
          ctrl_nxt.mode = MODE_HEADER;
        end
      end
      MODE_DROP: begin
      end
      default: begin
      end
    endcase

    if (words_after == 16'd0) begin
      ctrl_nxt.mode       = MODE_HEADER;
      ctrl_nxt.words_left = 15'd0;
      ctrl_nxt.position   = 14'd0;
    end
  end

endmodule

// File: design/gpu_command_packet_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gpu_command_packet_parser
// Parses a command buffer one word at a time and reports register writes,
// constant uploads, draws, unhandled opcodes and truncated packets.
//
// Input channel in_*: one command word plus the count of words after it.
// Output channel out_*: exactly one result word per input word, in order.
// A result is valid the cycle after its word is accepted unless the output stalls.
// Throughput: one word per cycle while in_ready is high; the parse state update
// and the single constant store write of a word both complete in the accepting cycle.
// Results go to an output register backed by a one-entry skid register, so
// in_ready stays high while one result waits and, outside the clearing sweep,
// drops only when both are full; nothing is lost or repeated while the receiver stalls.
// After reset the 1024-entry constant store is cleared, one entry per cycle,
// with in_ready low; named registers and parse state clear at once.
// ----------------------------------------------------------------------------
module gpu_command_packet_parser (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] in_cmd_word,
  input  logic [15:0] in_words_after,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_action,
  output logic [3:0]  out_reg_slot,
  output logic [9:0]  out_const_index,
  output logic [31:0] out_value,
  output logic        out_buffer_end
);
  import gcpp_pkg::*;

  ctrl_t   ctrl_r;
  ctrl_t   ctrl_nxt;
  result_t res;
  wr_t     wr;
  result_t out_r;
  result_t skid_r;
  logic    out_valid_r;
  logic    skid_full_r;
  logic [CONST_CW-1:0] clr_cnt_r;
  logic    clearing;
  logic    accept;
  logic [31:0] named_regs_r [NAMED_COUNT];
  logic [31:0] const_mem [CONST_WORDS];

  gcpp_step u_step (
    .ctrl        (ctrl_r),
    .cmd_word    (in_cmd_word),
    .words_after (in_words_after),
    .ctrl_nxt    (ctrl_nxt),
    .res         (res),
    .wr          (wr)
  );

  assign clearing = (clr_cnt_r != CONST_CW'(CONST_WORDS));
  assign in_ready = !skid_full_r && !clearing;
  assign accept   = in_valid && in_ready;

  // parse state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctrl_r <= '{mode: MODE_HEADER, default: '0};
    end else if (accept) begin
      ctrl_r <= ctrl_nxt;
    end
  end

  // clearing sweep
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else if (clearing) begin
      clr_cnt_r <= clr_cnt_r + CONST_CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (clearing) begin
      const_mem[clr_cnt_r[CONST_AW-1:0]] <= 32'd0;
    end else if (accept && wr.const_we) begin
      const_mem[wr.const_addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NAMED_COUNT; i++) begin
        named_regs_r[i] <= 32'd0;
      end
    end else if (accept && wr.named_we) begin
      named_regs_r[wr.named_slot] <= wr.data;
    end
  end

  // output register and skid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      skid_full_r <= 1'b0;
    end else if (!out_valid_r || out_ready) begin
      if (skid_full_r) begin
        out_valid_r <= 1'b1;
        skid_full_r <= 1'b0;
      end else begin
        out_valid_r <= accept;
      end
    end else if (accept) begin
      skid_full_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || out_ready) begin
      if (skid_full_r) begin
        out_r <= skid_r;
      end else if (accept) begin
        out_r <= res;
      end
    end else if (accept) begin
      skid_r <= res;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_action      = out_r.action;
  assign out_reg_slot    = out_r.reg_slot;
  assign out_const_index = out_r.const_index;
  assign out_value       = out_r.value;
  assign out_buffer_end  = out_r.buffer_end;

  a_skid_implies_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_full_r |-> out_valid_r)
    else $error("skid holds a word while output register is empty");

  a_no_accept_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clearing |-> !in_ready)
    else $error("input accepted during store clearing");

  a_buffer_end_header: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_words_after == 16'd0) |=> (ctrl_r.mode == MODE_HEADER &&
      ctrl_r.words_left == 15'd0))
    else $error("parser not back to header after buffer end");

  a_trunc_drop: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && res.action == ACT_TRUNC && in_words_after != 16'd0) |=>
      (ctrl_r.mode == MODE_DROP))
    else $error("truncated packet did not enter drop mode");

endmodule
